FILE: rtl/ebd_pkg.sv
// Shared types and constants of the energy beat detector.
package ebd_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int WORD_W    = 31;
  localparam int RATIO_W   = 10;
  localparam int SMOOTH_W  = 9;
  localparam int MUL_A_W   = 31;
  localparam int MUL_B_W   = 16;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int SQ_FRAC_W = 30;
  localparam int FRAC_W    = 8;
  localparam int CFG_IDX_W = 2;

  typedef logic [SAMPLE_W-1:0] mag_t;
  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [RATIO_W-1:0]  ratio_t;
  typedef logic [SMOOTH_W-1:0] smooth_t;
  typedef logic [MUL_A_W-1:0]  mul_a_t;
  typedef logic [MUL_B_W-1:0]  mul_b_t;
  typedef logic [PROD_W-1:0]   prod_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_ENERGY_FLOOR = 2'd0;
  localparam cfg_idx_t REG_BEAT_RATIO   = 2'd1;
  localparam cfg_idx_t REG_SMOOTHING    = 2'd2;

  localparam word_t   FLOOR_RESET  = 31'd10737;
  localparam ratio_t  RATIO_RESET  = 10'd410;
  localparam smooth_t SMOOTH_RESET = 9'd26;
  localparam smooth_t WEIGHT_ONE   = 9'd256;
  localparam prod_t   ROUND_HALF   = 47'd128;
  localparam word_t   Q30_ONE      = 31'h4000_0000;

endpackage

FILE: rtl/ebd_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module ebd_divider #(
  parameter int DIVIDEND_W = 44,
  parameter int DIVISOR_W  = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [STEP_W-1:0]     step_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  dsr_r;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DIVIDEND_W);
        quo_r  <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        quo_r  <= {quo_r[DIVIDEND_W-2:0], fits};
        rem_r  <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/energy_beat_detector.sv
// Top level of the energy beat detector: accumulator, sequencer and shared multiplier.
//
// Usage: audio words (signed Q1.15) enter on the in_ channel, one at a time, with
// in_last marking the final word of a block. Each word is squared and summed; on the
// last word the block's mean energy is found, compared against the running average
// and a beat flag, the energy, the updated average and the overflow flag leave as
// one word on the out_ channel. Words that are not last produce nothing.
// A word that is not last passes S_SQ and S_ACC with in_ready low, then back to S_IDLE.
// A last word goes on through S_DIV, S_RATIO, S_BEAT, S_BLEND and S_FIN; the sum has
// SUM_W = 30 + clog2(MAX_BLOCK + 1) bits, and the restoring divider gives one quotient
// bit per cycle, and one 31 x 16 multiplier is shared by the square, the ratio
// test and both terms of the average update.
// The result sits in an output register, so the next block is accepted while it
// waits; only a second result stalls the sequencer until out_ready takes the first.
// The cfg_ channel is always ready; write it only while the block is idle.
// Synchronous reset clears the accumulators, the average and the output valid, and
// restores the register defaults.
module energy_beat_detector #(
  parameter int MAX_BLOCK = 8192
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [15:0]             in_sample,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_beat,
  output logic [30:0]                    out_energy,
  output logic [30:0]                    out_average,
  output logic                           out_overflow,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [30:0]                    cfg_data
);

  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W = ebd_pkg::SQ_FRAC_W + CNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_ACC, S_DIV, S_RATIO, S_BEAT, S_BLEND, S_FIN
  } state_t;

  state_t                 state_r;
  ebd_pkg::mag_t          mag_r;
  logic                   last_r;
  logic                   add_r;
  logic                   sat_r;
  logic [SUM_W-1:0]       sum_r;
  logic [CNT_W-1:0]       count_r;
  ebd_pkg::word_t         avg_r;
  ebd_pkg::word_t         floor_r;
  ebd_pkg::ratio_t        ratio_r;
  ebd_pkg::smooth_t       smooth_r;
  ebd_pkg::prod_t         prod_r;
  ebd_pkg::prod_t         tmp_r;
  logic                   beat_r;
  logic                   out_valid_r;
  logic                   out_beat_r;
  ebd_pkg::word_t         out_energy_r;
  ebd_pkg::word_t         out_average_r;
  logic                   out_overflow_r;

  logic [SUM_W-1:0]       sum_nxt;
  logic [CNT_W-1:0]       count_nxt;
  ebd_pkg::mul_a_t        mul_a;
  ebd_pkg::mul_b_t        mul_b;
  ebd_pkg::smooth_t       weight;
  ebd_pkg::smooth_t       keep;
  ebd_pkg::word_t         energy;
  ebd_pkg::prod_t         blend;
  ebd_pkg::word_t         avg_nxt;
  logic                   beat_nxt;
  logic                   div_start;
  logic                   div_done;
  logic [SUM_W-1:0]       div_quo;
  logic                   out_free;

  assign sum_nxt   = add_r ? sum_r + SUM_W'(prod_r[ebd_pkg::SQ_FRAC_W:0]) : sum_r;
  assign count_nxt = add_r ? count_r + CNT_W'(1) : count_r;
  assign div_start = (state_r == S_ACC) && last_r;

  ebd_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (count_nxt),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign energy = div_quo[ebd_pkg::WORD_W-1:0];
  assign weight = (smooth_r > ebd_pkg::WEIGHT_ONE) ? ebd_pkg::WEIGHT_ONE : smooth_r;
  assign keep   = ebd_pkg::WEIGHT_ONE - weight;

  always_comb begin
    unique case (state_r) inside
      S_SQ: begin
        mul_a = ebd_pkg::mul_a_t'(mag_r);
        mul_b = mag_r;
      end
      S_RATIO: begin
        mul_a = avg_r;
        mul_b = ebd_pkg::mul_b_t'(ratio_r);
      end
      S_BEAT: begin
        mul_a = avg_r;
        mul_b = ebd_pkg::mul_b_t'(keep);
      end
      S_BLEND, S_FIN: begin
        mul_a = energy;
        mul_b = ebd_pkg::mul_b_t'(weight);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign beat_nxt = (avg_r > floor_r) &&
                    (ebd_pkg::prod_t'({energy, {ebd_pkg::FRAC_W{1'b0}}}) > prod_r);
  assign blend    = tmp_r + prod_r + ebd_pkg::ROUND_HALF;
  assign avg_nxt  = (weight == '0) ? avg_r
                                   : ebd_pkg::word_t'(blend >> ebd_pkg::FRAC_W);
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    prod_r <= ebd_pkg::prod_t'(mul_a) * ebd_pkg::prod_t'(mul_b);
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      count_r     <= '0;
      sat_r       <= 1'b0;
      avg_r       <= '0;
      floor_r     <= ebd_pkg::FLOOR_RESET;
      ratio_r     <= ebd_pkg::RATIO_RESET;
      smooth_r    <= ebd_pkg::SMOOTH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          ebd_pkg::REG_ENERGY_FLOOR: floor_r  <= cfg_data;
          ebd_pkg::REG_BEAT_RATIO:   ratio_r  <= cfg_data[ebd_pkg::RATIO_W-1:0];
          ebd_pkg::REG_SMOOTHING:    smooth_r <= cfg_data[ebd_pkg::SMOOTH_W-1:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mag_r  <= in_sample[15] ? ebd_pkg::mag_t'(~in_sample + 16'sd1)
                                    : ebd_pkg::mag_t'(in_sample);
            last_r <= in_last;
            add_r  <= count_r < CNT_W'(MAX_BLOCK);
            if (count_r >= CNT_W'(MAX_BLOCK)) begin
              sat_r <= 1'b1;
            end
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          sum_r   <= sum_nxt;
          count_r <= count_nxt;
          state_r <= last_r ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_RATIO;
          end
        end
        S_RATIO: begin
          state_r <= S_BEAT;
        end
        S_BEAT: begin
          beat_r  <= beat_nxt;
          state_r <= S_BLEND;
        end
        S_BLEND: begin
          tmp_r   <= prod_r;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_beat_r     <= beat_r;
            out_energy_r   <= energy;
            out_average_r  <= avg_nxt;
            out_overflow_r <= sat_r;
            avg_r          <= avg_nxt;
            sum_r          <= '0;
            count_r        <= '0;
            sat_r          <= 1'b0;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready     = (state_r == S_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = out_valid_r;
  assign out_beat     = out_beat_r;
  assign out_energy   = out_energy_r;
  assign out_average  = out_average_r;
  assign out_overflow = out_overflow_r;

endmodule

FILE: rtl/ebd_checker.sv
// Port-level assertions for the energy beat detector and their binding.
module ebd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_beat,
  input logic [30:0]        out_energy,
  input logic [30:0]        out_average,
  input logic               out_overflow,
  input logic               cfg_valid,
  input logic               cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_energy) &&
      $stable(out_average) && $stable(out_beat) && $stable(out_overflow))
    else $error("Result word changed while stalled.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Input accepted again before the previous word was processed.");

  a_no_result_after_plain_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("Result appeared right after an input word.");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_energy <= ebd_pkg::Q30_ONE && out_average <= ebd_pkg::Q30_ONE)
    else $error("Energy or average above unity.");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("Configuration write refused.");

endmodule

bind energy_beat_detector ebd_checker u_ebd_checker (.*);

FILE: tb/energy_beat_detector_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the energy beat detector with a built-in block energy predictor.
module energy_beat_detector_tb;

  localparam int BLOCK_MAX     = 8192;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 600;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int RANDOM_WORDS  = 300;

  typedef struct packed {
    logic           beat;
    ebd_pkg::word_t energy;
    ebd_pkg::word_t average;
    logic           overflow;
  } beat_report_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [15:0]       sample;
    logic              last;
    ebd_pkg::cfg_idx_t reg_idx;
    ebd_pkg::word_t    reg_data;
    logic              typed;
    beat_report_t      want;
  } script_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] in_sample = '0;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_beat;
  logic [30:0]        out_energy;
  logic [30:0]        out_average;
  logic               out_overflow;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  ebd_pkg::cfg_idx_t  cfg_index = '0;
  ebd_pkg::word_t     cfg_data = '0;

  // Predictor state and register copies.
  logic [43:0]      square_acc = '0;
  logic [13:0]      word_count = '0;
  ebd_pkg::word_t   avg_energy = '0;
  logic             count_full = 1'b0;
  ebd_pkg::word_t   floor_q = ebd_pkg::FLOOR_RESET;
  ebd_pkg::ratio_t  ratio_q = ebd_pkg::RATIO_RESET;
  ebd_pkg::smooth_t smooth_q = ebd_pkg::SMOOTH_RESET;

  beat_report_t block_reports[$];
  script_row_t  script[$];
  beat_report_t seen_report;

  int          mismatches = 0;
  int          words_sent = 0;
  int          reports_seen = 0;
  int          beats_seen = 0;
  int          overflows_seen = 0;
  int          reg_writes = 0;
  int          cycle_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        hold_wanted = 1'b0;
  logic        hold_taken = 1'b0;
  int          hold_left = 0;

  energy_beat_detector #(.MAX_BLOCK(BLOCK_MAX)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample   (in_sample),
    .in_last     (in_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_beat    (out_beat),
    .out_energy  (out_energy),
    .out_average (out_average),
    .out_overflow(out_overflow),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void accumulate_sample(input logic [15:0] raw, input logic is_last,
                                            output logic produced, output beat_report_t rep);
    logic [16:0] mag;
    logic [63:0] sq;
    logic [63:0] energy;
    logic [63:0] avg;
    logic [63:0] w;
    logic [63:0] next_avg;
    mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    sq = 64'(mag) * 64'(mag);
    rep = '0;
    produced = 1'b0;
    if (word_count < BLOCK_MAX) begin
      square_acc = square_acc + sq[43:0];
      word_count = word_count + 14'd1;
    end else begin
      count_full = 1'b1;
    end
    if (is_last) begin
      energy = (word_count != 0) ? (64'(square_acc) / 64'(word_count)) : 64'd0;
      avg = 64'(avg_energy);
      rep.beat = (avg > 64'(floor_q)) && ((energy << 8) > avg * 64'(ratio_q));
      w = (smooth_q > ebd_pkg::WEIGHT_ONE) ? 64'd256 : 64'(smooth_q);
      if (w == 0) begin
        next_avg = avg;
      end else begin
        next_avg = (avg * (64'd256 - w) + energy * w + 64'd128) >> 8;
      end
      avg_energy = next_avg[30:0];
      rep.energy = energy[30:0];
      rep.average = avg_energy;
      rep.overflow = count_full;
      produced = 1'b1;
      square_acc = '0;
      word_count = '0;
      count_full = 1'b0;
    end
  endfunction

  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      reports_seen++;
      beats_seen += out_beat;
      overflows_seen += out_overflow;
      if (block_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual beat %0d energy %0d avg %0d ovf %0d",
                 $time, out_beat, out_energy, out_average, out_overflow);
        mismatches++;
      end else begin
        seen_report = block_reports.pop_front();
        check_field("beat", seen_report.beat, out_beat);
        check_field("energy", seen_report.energy, out_energy);
        check_field("average", seen_report.average, out_average);
        check_field("overflow", seen_report.overflow, out_overflow);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (hold_wanted && !hold_taken) begin
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_word(input logic [15:0] s, input logic l, input logic typed,
                           input beat_report_t typed_rep);
    logic         produced;
    beat_report_t rep;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample <= s;
    in_last <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accumulate_sample(s, l, produced, rep);
    if (produced) begin
      block_reports.push_back(typed ? typed_rep : rep);
    end
    words_sent++;
  endtask

  task automatic send_block(input int len, input int shift);
    logic signed [15:0] v;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(15))
        0: v = 16'sh8000;
        1: v = 16'sh7FFF;
        default: begin
          v = 16'($urandom);
          v = v >>> shift;
        end
      endcase
      send_word(v, i == len - 1, 1'b0, '0);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (block_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input ebd_pkg::cfg_idx_t idx, input ebd_pkg::word_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ebd_pkg::REG_ENERGY_FLOOR: floor_q = data;
      ebd_pkg::REG_BEAT_RATIO:   ratio_q = data[ebd_pkg::RATIO_W-1:0];
      ebd_pkg::REG_SMOOTHING:    smooth_q = data[ebd_pkg::SMOOTH_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic program_random_regs();
    ebd_pkg::word_t floor_v;
    ebd_pkg::word_t ratio_v;
    ebd_pkg::word_t smooth_v;
    case ($urandom_range(5))
      0: floor_v = '0;
      1: floor_v = ebd_pkg::Q30_ONE;
      2: floor_v = 31'($urandom);
      default: floor_v = 31'($urandom_range(0, 200000));
    endcase
    case ($urandom_range(7))
      0: ratio_v = '0;
      1: ratio_v = 31'd1023;
      default: ratio_v = 31'($urandom_range(200, 600));
    endcase
    case ($urandom_range(9))
      0: smooth_v = '0;
      1: smooth_v = 31'(ebd_pkg::WEIGHT_ONE);
      2: smooth_v = 31'($urandom_range(257, 511));
      default: smooth_v = 31'($urandom_range(1, 255));
    endcase
    wait_idle();
    cfg_write(ebd_pkg::REG_ENERGY_FLOOR, floor_v);
    cfg_write(ebd_pkg::REG_BEAT_RATIO, ratio_v);
    cfg_write(ebd_pkg::REG_SMOOTHING, smooth_v);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned tx, input int unsigned rx, input int words);
    int target;
    int next_cfg;
    int len;
    target = words_sent + words;
    next_cfg = words_sent;
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    while (words_sent < target) begin
      if (words_sent >= next_cfg) begin
        program_random_regs();
        next_cfg = words_sent + words / 3;
      end
      case ($urandom_range(9))
        0: len = 1;
        8: len = $urandom_range(13, 64);
        9: len = $urandom_range(1, 4);
        default: len = $urandom_range(2, 12);
      endcase
      send_block(len, $urandom_range(0, 15));
    end
  endtask

  task automatic add_word(input logic [15:0] s, input logic l);
    script_row_t row;
    row = '{kind: ROW_WORD, sample: s, last: l, reg_idx: ebd_pkg::REG_ENERGY_FLOOR,
            reg_data: '0, typed: 1'b0, want: '0};
    script.push_back(row);
  endtask

  task automatic add_typed(input logic [15:0] s, input logic beat, input ebd_pkg::word_t energy,
                           input ebd_pkg::word_t average);
    script_row_t row;
    row = '{kind: ROW_WORD, sample: s, last: 1'b1, reg_idx: ebd_pkg::REG_ENERGY_FLOOR,
            reg_data: '0, typed: 1'b1, want: '{beat, energy, average, 1'b0}};
    script.push_back(row);
  endtask

  task automatic add_reg(input ebd_pkg::cfg_idx_t idx, input ebd_pkg::word_t data);
    script_row_t row;
    row = '{kind: ROW_REG, sample: '0, last: 1'b0, reg_idx: idx, reg_data: data,
            typed: 1'b0, want: '0};
    script.push_back(row);
  endtask

  initial begin
    add_typed(16'h0000, 1'b0, '0, '0);
    add_typed(16'h8000, 1'b0, ebd_pkg::Q30_ONE, 31'd109051904);
    add_word(16'h7FFF, 1'b0);
    add_word(16'h8001, 1'b1);
    add_word(16'h0001, 1'b0);
    add_word(16'hFFFF, 1'b0);
    add_word(16'h5555, 1'b0);
    add_word(16'hAAAA, 1'b1);
    add_reg(ebd_pkg::REG_SMOOTHING, 31'(ebd_pkg::WEIGHT_ONE));
    add_word(16'h4000, 1'b1);
    add_reg(ebd_pkg::REG_SMOOTHING, '0);
    add_word(16'd100, 1'b1);
    add_reg(ebd_pkg::REG_SMOOTHING, 31'd511);
    add_word(-16'sd200, 1'b1);
    add_reg(ebd_pkg::REG_BEAT_RATIO, '0);
    add_typed(16'h0001, 1'b1, 31'd1, 31'd1);
    add_typed(16'h0000, 1'b0, '0, '0);
    add_reg(ebd_pkg::REG_BEAT_RATIO, 31'd1023);
    add_reg(ebd_pkg::REG_ENERGY_FLOOR, '0);
    add_typed(16'h7FFF, 1'b0, 31'd1073676289, 31'd1073676289);
    add_word(16'h0001, 1'b1);
    add_typed(16'h8000, 1'b1, ebd_pkg::Q30_ONE, ebd_pkg::Q30_ONE);
    add_reg(ebd_pkg::REG_ENERGY_FLOOR, 31'h7FFF_FFFF);
    add_typed(16'h8000, 1'b0, ebd_pkg::Q30_ONE, ebd_pkg::Q30_ONE);
    add_reg(ebd_pkg::REG_ENERGY_FLOOR, ebd_pkg::FLOOR_RESET);
    add_reg(ebd_pkg::REG_BEAT_RATIO, 31'(ebd_pkg::RATIO_RESET));
    add_reg(ebd_pkg::REG_SMOOTHING, 31'(ebd_pkg::SMOOTH_RESET));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        wait_idle();
        cfg_write(script[i].reg_idx, script[i].reg_data);
        cfg_valid <= 1'b0;
      end else begin
        send_word(script[i].sample, script[i].last, script[i].typed, script[i].want);
      end
    end

    run_phase(36, 71, RANDOM_WORDS);
    run_phase(71, 36, RANDOM_WORDS);

    // The receiver stalls while short blocks keep coming, so the input backs up.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_wanted = 1'b1;
    repeat (10) send_block($urandom_range(1, 3), $urandom_range(0, 8));
    run_phase(0, 0, RANDOM_WORDS);

    wait_idle();
    $display("Sent %0d words and checked %0d block results (%0d beats, %0d saturated blocks).",
             words_sent, reports_seen, beats_seen, overflows_seen);
    $display("Made %0d register writes across directed corners and random settings.", reg_writes);
    if (mismatches == 0 && block_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
